@@ rtl/dmsfr_pkg.sv @@
package dmsfr_pkg;

    // Sizing
    localparam int NUM_PORTS   = 2;
    localparam int MAX_PAYLOAD = 64;
    localparam int RAM_DEPTH   = NUM_PORTS * MAX_PAYLOAD;
    localparam int ADDR_W      = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // Field widths
    localparam int PORT_W  = 1;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 7;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER  = 1'd1;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] HEAD_MARKER_RST = 8'd126;
    localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'd125;

    // Command ranges and nibble masks
    localparam logic [BYTE_W-1:0] NIBBLE_CMD_MAX = 8'h0F;
    localparam logic [BYTE_W-1:0] RAW_CMD_MIN    = 8'hF0;
    localparam logic [BYTE_W-1:0] HI_MASK        = 8'hF0;
    localparam logic [BYTE_W-1:0] LO_MASK        = 8'h0F;

    // Per-port parser step
    typedef enum logic [10:0] {
        P_HUNT     = 11'b000_0000_0001,
        P_CMD      = 11'b000_0000_0010,
        P_LEN      = 11'b000_0000_0100,
        P_NLEN_LO  = 11'b000_0000_1000,
        P_NLEN_HI  = 11'b000_0001_0000,
        P_DATA     = 11'b000_0010_0000,
        P_NDATA    = 11'b000_0100_0000,
        P_CRC      = 11'b000_1000_0000,
        P_NCRC_LO  = 11'b001_0000_0000,
        P_NCRC_HI  = 11'b010_0000_0000,
        P_END      = 11'b100_0000_0000
    } t_parse;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted byte and port
        logic process;   // run the parser step for the latched byte
        logic load;      // move one result into the output register
        logic advance;   // step to the next payload byte
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic deliver;   // the processed byte closes a good frame
        logic empty;     // that frame has no payload
        logic last;      // current result is the final one of the frame
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

@@ rtl/dmsfr_ram.sv @@
module dmsfr_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dmsfr_ctrl.sv @@
module dmsfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dmsfr_pkg::t_status i_status,
    output dmsfr_pkg::t_cmd    o_cmd
);
    import dmsfr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PROC = 4'b0010,
        S_RD   = 4'b0100,
        S_LD   = 4'b1000
    } t_ctrl_state;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // refuse transactions while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PROC;
                end
            end
            S_PROC: begin
                o_cmd.process = 1'b1;
                if (i_status.deliver) begin
                    n_state = i_status.empty ? S_LD : S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/dmsfr_dp.sv @@
module dmsfr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [dmsfr_pkg::PORT_W-1:0]       i_port,
    input  logic [dmsfr_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                               i_cfg_valid,
    input  logic [dmsfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmsfr_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [dmsfr_pkg::PORT_W-1:0]       o_out_port,
    output logic [dmsfr_pkg::BYTE_W-1:0]       o_command,
    output logic [dmsfr_pkg::LEN_W-1:0]        o_frame_length,
    output logic [dmsfr_pkg::IDX_W-1:0]        o_byte_index,
    output logic [dmsfr_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                               o_last,
    input  dmsfr_pkg::t_cmd                    i_cmd,
    output dmsfr_pkg::t_status                 o_status
);
    import dmsfr_pkg::*;

    // Configuration
    logic [BYTE_W-1:0] r_head;
    logic [BYTE_W-1:0] r_end;

    // Latched input transaction
    logic [PORT_W-1:0] r_port;
    logic [BYTE_W-1:0] r_byte;

    // Per-port parser state
    t_parse            r_step [NUM_PORTS];
    t_parse            n_step [NUM_PORTS];
    logic [BYTE_W-1:0] r_cmd  [NUM_PORTS];
    logic [BYTE_W-1:0] n_cmd  [NUM_PORTS];
    logic [CNT_W-1:0]  r_exp  [NUM_PORTS];
    logic [CNT_W-1:0]  n_exp  [NUM_PORTS];
    logic [CNT_W-1:0]  r_rcv  [NUM_PORTS];
    logic [CNT_W-1:0]  n_rcv  [NUM_PORTS];
    logic [BYTE_W-1:0] r_sck  [NUM_PORTS];
    logic [BYTE_W-1:0] n_sck  [NUM_PORTS];
    logic [BYTE_W-1:0] r_rck  [NUM_PORTS];
    logic [BYTE_W-1:0] n_rck  [NUM_PORTS];
    logic [3:0]        r_nib  [NUM_PORTS];
    logic [3:0]        n_nib  [NUM_PORTS];

    // Delivery
    logic [PORT_W-1:0] r_dl_port;
    logic [BYTE_W-1:0] r_dl_cmd;
    logic [LEN_W-1:0]  r_dl_len;
    logic [IDX_W-1:0]  r_k;

    // Output register
    logic              r_out_valid;
    logic [PORT_W-1:0] r_out_port;
    logic [BYTE_W-1:0] r_out_cmd;
    logic [LEN_W-1:0]  r_out_len;
    logic [IDX_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    // Payload store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              deliver;
    logic [CNT_W-1:0]  dl_exp;
    logic              port_ok;

    assign port_ok = (int'(r_port) < NUM_PORTS);

    // Parser step for the latched byte
    always_comb begin
        t_parse            st;
        logic [BYTE_W-1:0] b;
        logic [CNT_W-1:0]  ex;
        logic [CNT_W-1:0]  rc;
        logic [CNT_W-1:0]  rc_half;
        logic [BYTE_W-1:0] full;
        logic              stray;

        n_step = r_step;
        n_cmd  = r_cmd;
        n_exp  = r_exp;
        n_rcv  = r_rcv;
        n_sck  = r_sck;
        n_rck  = r_rck;
        n_nib  = r_nib;

        b       = r_byte;
        st      = r_step[r_port];
        ex      = r_exp[r_port];
        rc      = r_rcv[r_port];
        rc_half = rc >> 1;
        full    = {b[7:4], r_nib[r_port]};
        stray   = 1'b0;
        deliver = 1'b0;
        dl_exp  = ex;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = b;

        if (i_cmd.process && port_ok) begin
            case (st)
                P_HUNT: begin
                    stray = (b == r_head);
                end
                P_CMD: begin
                    if (b <= NIBBLE_CMD_MAX) begin
                        n_cmd[r_port]  = b;
                        n_step[r_port] = P_NLEN_LO;
                    end else if (b >= RAW_CMD_MIN) begin
                        n_cmd[r_port]  = b;
                        n_step[r_port] = P_LEN;
                    end else begin
                        stray = 1'b1;
                    end
                end
                P_LEN: begin
                    n_exp[r_port]  = b;
                    n_step[r_port] = (b == '0) ? P_END : P_DATA;
                end
                P_NLEN_LO: begin
                    if ((b & HI_MASK) == '0) begin
                        n_exp[r_port]  = b;
                        n_step[r_port] = P_NLEN_HI;
                    end else begin
                        stray = 1'b1;
                    end
                end
                P_NLEN_HI: begin
                    if ((b & LO_MASK) == '0) begin
                        n_exp[r_port] = ex | b;
                        if ((ex | b) == '0) begin
                            n_step[r_port] = P_END;
                        end else if ((ex[0] | b[0]) == 1'b1) begin
                            // odd nibble count cannot form whole bytes
                            n_step[r_port] = P_HUNT;
                        end else begin
                            n_step[r_port] = P_NDATA;
                        end
                    end else begin
                        stray = 1'b1;
                    end
                end
                P_DATA: begin
                    if (int'(rc) < MAX_PAYLOAD) begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(int'(r_port) * MAX_PAYLOAD + int'(rc));
                    end
                    n_rck[r_port] = r_rck[r_port] ^ b;
                    n_rcv[r_port] = rc + 1'b1;
                    if (CNT_W'(rc + 1'b1) == ex) begin
                        n_step[r_port] = P_CRC;
                    end
                end
                P_NDATA: begin
                    if (rc[0] == 1'b0) begin
                        // hold the low nibble until its partner arrives
                        if ((b & HI_MASK) == '0) begin
                            n_nib[r_port] = b[3:0];
                            n_rcv[r_port] = rc + 1'b1;
                        end else begin
                            stray = 1'b1;
                        end
                    end else begin
                        if ((b & LO_MASK) == '0) begin
                            if (int'(rc_half) < MAX_PAYLOAD) begin
                                ram_we        = 1'b1;
                                ram_waddr     = ADDR_W'(int'(r_port) * MAX_PAYLOAD
                                                        + int'(rc_half));
                                ram_wdata     = full;
                                n_rck[r_port] = r_rck[r_port] ^ full;
                            end
                            n_rcv[r_port] = rc + 1'b1;
                            if (CNT_W'(rc + 1'b1) == ex) begin
                                n_step[r_port] = P_NCRC_LO;
                            end
                        end else begin
                            stray = 1'b1;
                        end
                    end
                end
                P_CRC: begin
                    n_sck[r_port]  = b;
                    n_step[r_port] = P_END;
                end
                P_NCRC_LO: begin
                    if ((b & HI_MASK) == '0) begin
                        n_sck[r_port]  = b;
                        n_step[r_port] = P_NCRC_HI;
                    end else begin
                        stray = 1'b1;
                    end
                end
                P_NCRC_HI: begin
                    if ((b & LO_MASK) == '0) begin
                        n_sck[r_port]  = r_sck[r_port] | b;
                        n_exp[r_port]  = ex >> 1;
                        n_step[r_port] = P_END;
                    end else begin
                        stray = 1'b1;
                    end
                end
                P_END: begin
                    if (b == r_head) begin
                        stray = 1'b1;
                    end else begin
                        n_step[r_port] = P_HUNT;
                        if (b == r_end && r_rck[r_port] == r_sck[r_port]
                            && int'(ex) <= MAX_PAYLOAD) begin
                            deliver = 1'b1;
                        end
                    end
                end
                default: begin
                    n_step[r_port] = P_HUNT;
                end
            endcase

            // head marker restarts the frame, anything else drops it
            if (stray) begin
                if (b == r_head) begin
                    n_step[r_port] = P_CMD;
                    n_cmd[r_port]  = '0;
                    n_exp[r_port]  = '0;
                    n_rcv[r_port]  = '0;
                    n_sck[r_port]  = '0;
                    n_rck[r_port]  = '0;
                end else begin
                    n_step[r_port] = P_HUNT;
                end
            end
        end
    end

    assign ram_raddr = ADDR_W'(int'(r_dl_port) * MAX_PAYLOAD + int'(r_k));

    dmsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_status.deliver  = deliver;
        o_status.empty    = (dl_exp == '0);
        o_status.last     = (r_dl_len == '0) || ((LEN_W'(r_k) + 1'b1) == r_dl_len);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // Configuration and latched transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= HEAD_MARKER_RST;
            r_end  <= END_MARKER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HEAD_MARKER: r_head <= i_cfg_data;
                CFG_END_MARKER:  r_end  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_port <= i_port;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_step[p] <= P_HUNT;
                r_cmd[p]  <= '0;
                r_exp[p]  <= '0;
                r_rcv[p]  <= '0;
                r_sck[p]  <= '0;
                r_rck[p]  <= '0;
                r_nib[p]  <= '0;
            end
        end else begin
            r_step <= n_step;
            r_cmd  <= n_cmd;
            r_exp  <= n_exp;
            r_rcv  <= n_rcv;
            r_sck  <= n_sck;
            r_rck  <= n_rck;
            r_nib  <= n_nib;
        end
    end

    // Delivery bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (deliver) begin
            r_k <= '0;
        end else if (i_cmd.advance) begin
            r_k <= r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deliver) begin
            r_dl_port <= r_port;
            r_dl_cmd  <= r_cmd[r_port];
            r_dl_len  <= dl_exp[LEN_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_port <= r_dl_port;
            r_out_cmd  <= r_dl_cmd;
            r_out_len  <= r_dl_len;
            r_out_idx  <= r_k;
            r_out_byte <= (r_dl_len == '0) ? '0 : ram_rdata;
            r_out_last <= o_status.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_port     = r_out_port;
    assign o_command      = r_out_cmd;
    assign o_frame_length = r_out_len;
    assign o_byte_index   = r_out_idx;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;

endmodule

@@ rtl/dual_mode_serial_frame_receiver_top.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_port, i_rx_byte
// result    out        o_out_valid / i_out_ready  o_out_port, o_command, o_frame_length,
//                                                 o_byte_index, o_payload_byte, o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A received byte is accepted in S_IDLE; then, in S_PROC, the parser step of its port
// runs and writes the payload store.
// A byte that closes a good frame then streams its results, each through a store
// read (S_RD) and an output load (S_LD), set by the registered read port of the store;
// an empty frame skips the store read and loads its single result in S_LD.
// Output stalls hold the stream; the last result waits in the output register
// while the next input byte is already accepted; none is accepted before that load.
// Synchronous active-low reset; the payload store needs no clearing pass.
module dual_mode_serial_frame_receiver_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input byte transactions
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dmsfr_pkg::PORT_W-1:0]       i_port,
    input  logic [dmsfr_pkg::BYTE_W-1:0]       i_rx_byte,
    // result transactions
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dmsfr_pkg::PORT_W-1:0]       o_out_port,
    output logic [dmsfr_pkg::BYTE_W-1:0]       o_command,
    output logic [dmsfr_pkg::LEN_W-1:0]        o_frame_length,
    output logic [dmsfr_pkg::IDX_W-1:0]        o_byte_index,
    output logic [dmsfr_pkg::BYTE_W-1:0]       o_payload_byte,
    output logic                               o_last,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dmsfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmsfr_pkg::BYTE_W-1:0]       i_cfg_data
);
    import dmsfr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Marker registers take a write in any cycle out of reset.
    assign o_cfg_ready = i_rst_n;

    // Sequencer: accept, parse, then walk the stored payload on delivery.
    dmsfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Per-port parsers, payload store and output register.
    dmsfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_port         (i_port),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_port     (o_out_port),
        .o_command      (o_command),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule
